// File: rtl/core/slpt_pkg.sv
// shared constants, command and status codes, address helpers for the page table mmu
package slpt_pkg;

	localparam int PAGE_BYTES     = 256;
	localparam int PAGE_BITS      = 8;
	localparam int NUM_PAGES      = 64;
	localparam int PAGE_IDX_BITS  = 6;
	localparam int POINTER_BASE   = 64;
	localparam int MEM_BYTES      = PAGE_BYTES * NUM_PAGES;
	localparam int ADDR_BITS      = 14;
	localparam int BYTE_BITS      = 8;
	localparam int PROC_BITS      = 6;
	localparam int COUNT_BITS     = 7;

	typedef enum logic [1:0] {
		CMD_NEW   = 2'd0,
		CMD_KILL  = 2'd1,
		CMD_STORE = 2'd2,
		CMD_LOAD  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_TABLE = 2'd1,
		STAT_NO_DATA  = 2'd2
	} status_t;

	// byte address of a page and offset, wrapped to the memory size
	function automatic logic [ADDR_BITS-1:0] page_addr(input logic [BYTE_BITS-1:0] page,
		input logic [PAGE_BITS-1:0] offset);
		return {page[PAGE_IDX_BITS-1:0], offset};
	endfunction

	// byte address of a process's table pointer slot in page 0
	function automatic logic [ADDR_BITS-1:0] ptr_addr(input logic [PROC_BITS-1:0] proc);
		return ADDR_BITS'(POINTER_BASE) + ADDR_BITS'(proc);
	endfunction

endpackage

// File: rtl/core/single_level_page_table_mmu.sv
// top level of the single level page table mmu: command sequencer around one byte ram
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------
//  request | req_valid, req_stall | cmd, proc_id, virt_addr, store_value, pages_wanted
//  result  | rsp_valid, rsp_stall | phys_addr, load_value, status
//
// store and load step through pointer read, table read, data access, result
// new process scans the map byte by byte and writes two bytes per page taken; the map
//   scan resumes after the last page found
// kill process walks the table, freeing each mapped page, then the table page and pointer;
//   every step is set by the one ram port, one read or one write per cycle
// after reset a clearing pass writes all 16384 ram bytes (byte 0 gets one);
//   req_stall stays high during it and whenever a transaction is in progress
// a finished result waits in the output register while the next request is taken
module single_level_page_table_mmu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [1:0]                           cmd,
	input  logic [slpt_pkg::PROC_BITS-1:0]       proc_id,
	input  logic [slpt_pkg::ADDR_BITS-1:0]       virt_addr,
	input  logic [slpt_pkg::BYTE_BITS-1:0]       store_value,
	input  logic [slpt_pkg::COUNT_BITS-1:0]      pages_wanted,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [slpt_pkg::ADDR_BITS-1:0]       phys_addr,
	output logic [slpt_pkg::BYTE_BITS-1:0]       load_value,
	output logic [1:0]                           status
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PTR,
		S_XLATE,
		S_SCAN,
		S_SET_PTR,
		S_SET_ENTRY,
		S_NEXT,
		S_KILL_RD,
		S_KILL_CK,
		S_FREE_TABLE,
		S_FREE_PTR,
		S_DONE
	} state_t;

	localparam int AW = slpt_pkg::ADDR_BITS;
	localparam int BW = slpt_pkg::BYTE_BITS;
	localparam int PB = slpt_pkg::PAGE_BITS;

	state_t                             state_q;
	slpt_pkg::cmd_t                     cmd_q;
	logic [slpt_pkg::PROC_BITS-1:0]     proc_q;
	logic [AW-1:0]                      vaddr_q;
	logic [BW-1:0]                      value_q;
	logic [slpt_pkg::COUNT_BITS-1:0]    count_q;
	logic [slpt_pkg::COUNT_BITS-1:0]    v_q;
	logic [AW-1:0]                      idx_q;      // shared walk counter: clear, scan, kill
	logic [BW-1:0]                      table_q;
	logic [BW-1:0]                      page_q;
	logic [AW-1:0]                      paddr_q;
	slpt_pkg::status_t                  status_q;
	logic                               taking_table_q;
	logic                               rsp_valid_q;
	logic [AW-1:0]                      phys_addr_q;
	logic [BW-1:0]                      load_value_q;
	slpt_pkg::status_t                  status_out_q;

	// ram port
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [BW-1:0] mem_wdata;
	logic [BW-1:0] mem_rdata;

	// shared incrementer and end compare
	logic [AW-1:0]                   idx_inc;
	logic                            walk_last;
	logic                            clear_last;
	logic [slpt_pkg::COUNT_BITS-1:0] v_inc;
	logic                            req_accept;
	logic                            rsp_free;
	logic [AW-1:0]                   xlate_addr;

	assign idx_inc    = idx_q + AW'(1);
	assign walk_last  = (idx_q == AW'(slpt_pkg::NUM_PAGES - 1));
	assign clear_last = (idx_q == AW'(slpt_pkg::MEM_BYTES - 1));
	assign v_inc      = v_q + slpt_pkg::COUNT_BITS'(1);
	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign xlate_addr = slpt_pkg::page_addr(mem_rdata, vaddr_q[PB-1:0]);

	slpt_ram #(
		.WIDTH(BW),
		.DEPTH(slpt_pkg::MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// ram control, one access per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				// zero the memory, mark page 0 used
				mem_we    = 1'b1;
				mem_addr  = idx_q;
				mem_wdata = (idx_q == '0) ? BW'(1) : '0;
			end
			S_IDLE: begin
				if (req_valid) begin
					mem_re = 1'b1;
					if (slpt_pkg::cmd_t'(cmd) == slpt_pkg::CMD_NEW) begin
						mem_addr = '0;
					end else begin
						mem_addr = slpt_pkg::ptr_addr(proc_id);
					end
				end
			end
			S_PTR: begin
				// rdata holds the table page
				mem_re = 1'b1;
				if (cmd_q == slpt_pkg::CMD_KILL) begin
					mem_addr = slpt_pkg::page_addr(mem_rdata, '0);
				end else begin
					mem_addr = slpt_pkg::page_addr(mem_rdata,
						PB'(vaddr_q[AW-1:PB]));
				end
			end
			S_XLATE: begin
				// rdata holds the physical page
				mem_addr = xlate_addr;
				if (cmd_q == slpt_pkg::CMD_STORE) begin
					mem_we    = 1'b1;
					mem_wdata = value_q;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_SCAN: begin
				if (mem_rdata == '0) begin
					mem_we    = 1'b1;
					mem_addr  = idx_q;
					mem_wdata = BW'(1);
				end else if (!walk_last) begin
					mem_re   = 1'b1;
					mem_addr = idx_inc;
				end
			end
			S_SET_PTR: begin
				mem_we    = 1'b1;
				mem_addr  = slpt_pkg::ptr_addr(proc_q);
				mem_wdata = table_q;
			end
			S_SET_ENTRY: begin
				mem_we    = 1'b1;
				mem_addr  = slpt_pkg::page_addr(table_q, PB'(v_q));
				mem_wdata = page_q;
			end
			S_NEXT: begin
				if (!walk_last) begin
					mem_re   = 1'b1;
					mem_addr = idx_inc;
				end
			end
			S_KILL_RD: begin
				mem_re   = 1'b1;
				mem_addr = slpt_pkg::page_addr(table_q, idx_q[PB-1:0]);
			end
			S_KILL_CK: begin
				if (mem_rdata != '0) begin
					mem_we   = 1'b1;
					mem_addr = AW'(mem_rdata);
				end else if (!walk_last) begin
					mem_re   = 1'b1;
					mem_addr = slpt_pkg::page_addr(table_q, idx_inc[PB-1:0]);
				end
			end
			S_FREE_TABLE: begin
				mem_we   = 1'b1;
				mem_addr = AW'(table_q);
			end
			S_FREE_PTR: begin
				mem_we   = 1'b1;
				mem_addr = slpt_pkg::ptr_addr(proc_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			cmd_q          <= slpt_pkg::CMD_NEW;
			proc_q         <= '0;
			vaddr_q        <= '0;
			value_q        <= '0;
			count_q        <= '0;
			v_q            <= '0;
			idx_q          <= '0;
			table_q        <= '0;
			page_q         <= '0;
			paddr_q        <= '0;
			status_q       <= slpt_pkg::STAT_OK;
			taking_table_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
			phys_addr_q    <= '0;
			load_value_q   <= '0;
			status_out_q   <= slpt_pkg::STAT_OK;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clear_last) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_IDLE: begin
					if (req_accept) begin
						cmd_q          <= slpt_pkg::cmd_t'(cmd);
						proc_q         <= proc_id;
						vaddr_q        <= virt_addr;
						value_q        <= store_value;
						count_q        <= pages_wanted;
						status_q       <= slpt_pkg::STAT_OK;
						paddr_q        <= '0;
						idx_q          <= '0;
						v_q            <= '0;
						taking_table_q <= 1'b1;
						if (slpt_pkg::cmd_t'(cmd) == slpt_pkg::CMD_NEW) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_PTR;
						end
					end
				end
				S_PTR: begin
					table_q <= mem_rdata;
					if (cmd_q == slpt_pkg::CMD_KILL) begin
						state_q <= S_KILL_CK;
					end else begin
						state_q <= S_XLATE;
					end
				end
				S_XLATE: begin
					paddr_q <= xlate_addr;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (mem_rdata == '0) begin
						if (taking_table_q) begin
							table_q <= idx_q[BW-1:0];
							state_q <= S_SET_PTR;
						end else begin
							page_q  <= idx_q[BW-1:0];
							state_q <= S_SET_ENTRY;
						end
					end else if (walk_last) begin
						status_q <= taking_table_q ? slpt_pkg::STAT_NO_TABLE
							: slpt_pkg::STAT_NO_DATA;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SET_PTR: begin
					taking_table_q <= 1'b0;
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_SET_ENTRY: begin
					v_q <= v_inc;
					if (v_inc == count_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// pages up to the last one found are all in use
					if (walk_last) begin
						status_q <= slpt_pkg::STAT_NO_DATA;
						state_q  <= S_DONE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_SCAN;
					end
				end
				S_KILL_RD: begin
					state_q <= S_KILL_CK;
				end
				S_KILL_CK: begin
					if (walk_last) begin
						state_q <= S_FREE_TABLE;
					end else begin
						idx_q <= idx_inc;
						// a free may hit a later entry, so read again after a write
						if (mem_rdata != '0) begin
							state_q <= S_KILL_RD;
						end
					end
				end
				S_FREE_TABLE: begin
					state_q <= S_FREE_PTR;
				end
				S_FREE_PTR: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						status_out_q <= status_q;
						if (cmd_q == slpt_pkg::CMD_STORE || cmd_q == slpt_pkg::CMD_LOAD) begin
							phys_addr_q <= paddr_q;
						end else begin
							phys_addr_q <= '0;
						end
						if (cmd_q == slpt_pkg::CMD_LOAD) begin
							load_value_q <= mem_rdata;
						end else begin
							load_value_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign phys_addr  = phys_addr_q;
	assign load_value = load_value_q;
	assign status     = status_out_q;

`ifndef ASSERT_OFF
	// one ram access per cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("ram read and write in the same cycle");

	// an accepted transaction leaves idle at once
	assert property (@(posedge clk) disable iff (!arst_n) req_accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a transaction");

	// map scan and table walk stay inside the free map
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_KILL_CK || state_q == S_NEXT)
		|-> idx_q < AW'(slpt_pkg::NUM_PAGES))
		else $error("walk counter beyond the page count");

	// a result is only loaded when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && rsp_stall) |=> $stable(phys_addr_q))
		else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/slpt_ram.sv
// generic single port ram with registered read
module slpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: test/tb_single_level_page_table_mmu.sv
// self-checking testbench for the single level page table mmu with a shadow memory predictor
module tb_single_level_page_table_mmu;
	timeunit 1ns;
	timeprecision 1ps;

	import slpt_pkg::*;

	// run length and limits, in items and clock cycles
	localparam int RANDOM_ITEMS = 1330;
	localparam int HOLD_AT_ITEM = 600;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 400;
	// clearing pass, then the slowest item (a full allocation) with the longest gaps, many times over
	localparam int CYCLE_LIMIT  = 16384 + 1400 * 2000;

	typedef struct {
		cmd_t                  cmd;
		logic [PROC_BITS-1:0]  proc;
		logic [ADDR_BITS-1:0]  vaddr;
		logic [BYTE_BITS-1:0]  value;
		logic [COUNT_BITS-1:0] count;
	} mmu_req_t;

	typedef struct {
		logic [ADDR_BITS-1:0] paddr;
		logic [BYTE_BITS-1:0] data;
		status_t              stat;
	} mmu_rsp_t;

	// one directed row: the request, and a typed-in result where it is obvious
	typedef struct {
		mmu_req_t req;
		bit       fixed;
		mmu_rsp_t rsp;
	} dir_row_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  req_valid   = 1'b0;
	logic                  req_stall;
	logic [1:0]            cmd         = '0;
	logic [PROC_BITS-1:0]  proc_id     = '0;
	logic [ADDR_BITS-1:0]  virt_addr   = '0;
	logic [BYTE_BITS-1:0]  store_value = '0;
	logic [COUNT_BITS-1:0] pages_wanted = '0;
	logic                  rsp_valid;
	logic                  rsp_stall   = 1'b0;
	logic [ADDR_BITS-1:0]  phys_addr;
	logic [BYTE_BITS-1:0]  load_value;
	logic [1:0]            status;

	// shadow copy of the physical memory, and results still owed by the block
	logic [BYTE_BITS-1:0] shadow_mem [0:MEM_BYTES-1];
	mmu_rsp_t             pending_results [$];

	int error_count = 0;
	int items_sent  = 0;
	int cycle_count = 0;
	int no_gap_left = 0;
	bit long_hold   = 1'b0;

	single_level_page_table_mmu dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.proc_id      (proc_id),
		.virt_addr    (virt_addr),
		.store_value  (store_value),
		.pages_wanted (pages_wanted),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.phys_addr    (phys_addr),
		.load_value   (load_value),
		.status       (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// byte address of offset off in page pg, wrapped to the memory size
	function automatic logic [ADDR_BITS-1:0] mem_index(input logic [BYTE_BITS-1:0] pg,
		input int off);
		return ADDR_BITS'((int'(pg) * PAGE_BYTES + off) % MEM_BYTES);
	endfunction

	// address of the table pointer byte of a process
	function automatic logic [ADDR_BITS-1:0] ptr_slot(input logic [PROC_BITS-1:0] proc);
		return ADDR_BITS'((POINTER_BASE + int'(proc)) % MEM_BYTES);
	endfunction

	// first-fit scan of the free map, marks the page used when found
	function automatic bit take_free_page(output logic [BYTE_BITS-1:0] pg);
		for (int p = 0; p < NUM_PAGES; p++) begin
			if (shadow_mem[p] == '0) begin
				shadow_mem[p] = 8'd1;
				pg = BYTE_BITS'(p);
				return 1'b1;
			end
		end
		pg = '0;
		return 1'b0;
	endfunction

	// pointer, then table entry, then physical page plus offset
	function automatic logic [ADDR_BITS-1:0] translated(input logic [PROC_BITS-1:0] proc,
		input logic [ADDR_BITS-1:0] vaddr);
		logic [BYTE_BITS-1:0] tbl;
		logic [BYTE_BITS-1:0] pg;
		tbl = shadow_mem[ptr_slot(proc)];
		pg  = shadow_mem[mem_index(tbl, int'(vaddr) / PAGE_BYTES)];
		return mem_index(pg, int'(vaddr) % PAGE_BYTES);
	endfunction

	// executes one command on the shadow memory and returns the result it must give
	function automatic mmu_rsp_t run_command(input mmu_req_t q);
		mmu_rsp_t             r;
		logic [BYTE_BITS-1:0] tbl;
		logic [BYTE_BITS-1:0] pg;
		logic [ADDR_BITS-1:0] a;
		r = '{paddr: '0, data: '0, stat: STAT_OK};
		case (q.cmd)
			CMD_NEW: begin
				if (!take_free_page(tbl)) begin
					// no page for the table: pointer slot is left alone
					r.stat = STAT_NO_TABLE;
				end else begin
					shadow_mem[ptr_slot(q.proc)] = tbl;
					// stop at the first failure, pages already taken stay taken
					for (int v = 0; v < int'(q.count); v++) begin
						if (!take_free_page(pg)) begin
							r.stat = STAT_NO_DATA;
							break;
						end
						shadow_mem[mem_index(tbl, v)] = pg;
					end
				end
			end
			CMD_KILL: begin
				// an unassigned process walks page 0 as its table
				tbl = shadow_mem[ptr_slot(q.proc)];
				for (int v = 0; v < NUM_PAGES; v++) begin
					pg = shadow_mem[mem_index(tbl, v)];
					if (pg != '0)
						shadow_mem[ADDR_BITS'(pg)] = '0;
				end
				shadow_mem[ADDR_BITS'(tbl)] = '0;
				shadow_mem[ptr_slot(q.proc)] = '0;
			end
			CMD_STORE: begin
				a = translated(q.proc, q.vaddr);
				shadow_mem[a] = q.value;
				r.paddr = a;
			end
			default: begin
				a = translated(q.proc, q.vaddr);
				r.paddr = a;
				r.data  = shadow_mem[a];
			end
		endcase
		return r;
	endfunction

	// a random process that currently has a nonzero table pointer
	function automatic bit pick_live_proc(output logic [PROC_BITS-1:0] p);
		int live [$];
		for (int i = 0; i < 64; i++)
			if (shadow_mem[ptr_slot(PROC_BITS'(i))] != '0)
				live.push_back(i);
		p = PROC_BITS'($urandom);
		if (live.size() == 0)
			return 1'b0;
		p = PROC_BITS'(live[$urandom_range(0, live.size() - 1)]);
		return 1'b1;
	endfunction

	// mostly well-formed traffic: new for free slots, kill and access for live processes
	function automatic mmu_req_t pick_command();
		mmu_req_t             q;
		int                   roll;
		int                   mapped [$];
		logic [PROC_BITS-1:0] p;
		logic [BYTE_BITS-1:0] tbl;
		q.cmd   = CMD_LOAD;
		q.proc  = PROC_BITS'($urandom);
		q.vaddr = ADDR_BITS'($urandom);
		q.value = BYTE_BITS'($urandom);
		q.count = COUNT_BITS'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			q.cmd = CMD_NEW;
			for (int t = 0; t < 4; t++)
				if (shadow_mem[ptr_slot(q.proc)] != '0)
					q.proc = PROC_BITS'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 80)
				q.count = COUNT_BITS'($urandom_range(0, 8));
			else if (roll < 97)
				q.count = COUNT_BITS'($urandom_range(9, 40));
			else
				q.count = COUNT_BITS'($urandom_range(41, 127));
		end else if (roll < 18) begin
			q.cmd = CMD_KILL;
			// now and then kill whatever slot, assigned or not
			if ($urandom_range(0, 19) != 0 && pick_live_proc(p))
				q.proc = p;
		end else begin
			q.cmd = ($urandom_range(0, 1) != 0) ? CMD_STORE : CMD_LOAD;
			if ($urandom_range(0, 9) != 0 && pick_live_proc(p)) begin
				q.proc = p;
				tbl = shadow_mem[ptr_slot(p)];
				for (int v = 0; v < NUM_PAGES; v++)
					if (shadow_mem[mem_index(tbl, v)] != '0)
						mapped.push_back(v);
				if (mapped.size() > 0)
					q.vaddr = ADDR_BITS'(mapped[$urandom_range(0, mapped.size() - 1)]
						* PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
			end
		end
		return q;
	endfunction

	function automatic dir_row_t row(input cmd_t c, input int p, input int va, input int val,
		input int cnt, input bit fixed, input int pa, input status_t st);
		dir_row_t d;
		d.req   = '{cmd: c, proc: PROC_BITS'(p), vaddr: ADDR_BITS'(va),
			value: BYTE_BITS'(val), count: COUNT_BITS'(cnt)};
		d.fixed = fixed;
		d.rsp   = '{paddr: ADDR_BITS'(pa), data: '0, stat: st};
		return d;
	endfunction

	// offer one transaction, hold it until taken, then predict and idle a while
	task automatic drive_command(input mmu_req_t q, input bit fixed, input mmu_rsp_t fixed_rsp);
		mmu_rsp_t r;
		int       gap;
		int       roll;
		req_valid    <= 1'b1;
		cmd          <= q.cmd;
		proc_id      <= q.proc;
		virt_addr    <= q.vaddr;
		store_value  <= q.value;
		pages_wanted <= q.count;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		r = run_command(q);
		pending_results.push_back(fixed ? fixed_rsp : r);
		items_sent++;
		// gap before the next one: mostly none or short, a few long, some bursts
		gap = 0;
		if (no_gap_left > 0) begin
			no_gap_left--;
		end else if (!long_hold) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				no_gap_left = $urandom_range(30, 80);
			else if (roll < 60)
				gap = 0;
			else if (roll < 88)
				gap = $urandom_range(1, 3);
			else if (roll < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(30, 80);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: compare each taken transaction with the oldest prediction
	always @(posedge clk) begin
		mmu_rsp_t e;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected transaction phys_addr %h load_value %h status %h",
					$time, phys_addr, load_value, status);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (phys_addr !== e.paddr) begin
					$display("%0t phys_addr expected %h actual %h", $time, e.paddr, phys_addr);
					error_count++;
				end
				if (load_value !== e.data) begin
					$display("%0t load_value expected %h actual %h", $time, e.data, load_value);
					error_count++;
				end
				if (status !== e.stat) begin
					$display("%0t status expected %h actual %h", $time, e.stat, status);
					error_count++;
				end
			end
		end
	end

	// receiver stalls, with one long hold so the block backs up into the request side
	initial begin
		int  roll;
		int  span;
		bit  held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && items_sent >= HOLD_AT_ITEM) begin
				held      = 1'b1;
				long_hold = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					rsp_stall <= 1'b0;
					span = $urandom_range(1, 8);
				end else if (roll < 85) begin
					rsp_stall <= 1'b1;
					span = $urandom_range(1, 3);
				end else if (roll < 95) begin
					rsp_stall <= 1'b0;
					span = $urandom_range(20, 80);
				end else begin
					rsp_stall <= 1'b1;
					span = $urandom_range(10, 60);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		dir_row_t dir_rows [$];
		mmu_rsp_t none;
		int       waited;
		none = '{paddr: '0, data: '0, stat: STAT_OK};
		for (int i = 0; i < MEM_BYTES; i++)
			shadow_mem[i] = '0;
		// page 0 is marked used at reset
		shadow_mem[0] = 8'd1;

		// loads right after reset go through page 0 as the table
		dir_rows.push_back(row(CMD_LOAD, 0, 0, 0, 0, 1, 256, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 63, 16383, 0, 0, 1, 255, STAT_OK));
		dir_rows.push_back(row(CMD_NEW, 0, 0, 0, 0, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_NEW, 1, 0, 0, 2, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_STORE, 1, 'h0001, 'hFF, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 1, 'h0001, 0, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_STORE, 1, 'h01FF, 'hA5, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 1, 'h01FF, 0, 0, 0, 0, STAT_OK));
		// unmapped virtual page lands in page 0
		dir_rows.push_back(row(CMD_STORE, 1, 'h3FFF, 'h5A, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 1, 'h3FFF, 0, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_KILL, 1, 0, 0, 0, 1, 0, STAT_OK));
		// exhaust memory on data pages, then on the table page
		dir_rows.push_back(row(CMD_NEW, 63, 0, 0, 64, 1, 0, STAT_NO_DATA));
		dir_rows.push_back(row(CMD_NEW, 5, 0, 0, 0, 1, 0, STAT_NO_TABLE));
		dir_rows.push_back(row(CMD_STORE, 63, 'h3FFF, 'hFF, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_STORE, 63, 'h2A00, 'h00, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 63, 'h2A00, 0, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_KILL, 63, 0, 0, 0, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_KILL, 0, 0, 0, 0, 1, 0, STAT_OK));
		// kill of an unassigned process frees page 0 itself
		dir_rows.push_back(row(CMD_KILL, 10, 0, 0, 0, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_NEW, 2, 0, 0, 3, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_STORE, 2, 'h0105, 'h3C, 0, 0, 0, STAT_OK));
		dir_rows.push_back(row(CMD_LOAD, 2, 'h0105, 0, 0, 0, 0, STAT_OK));
		// oversized request runs until memory is gone
		dir_rows.push_back(row(CMD_NEW, 3, 0, 0, 127, 1, 0, STAT_NO_DATA));
		dir_rows.push_back(row(CMD_KILL, 3, 0, 0, 0, 1, 0, STAT_OK));
		dir_rows.push_back(row(CMD_KILL, 2, 0, 0, 0, 1, 0, STAT_OK));
		// takes page 0 back so the map is sane again
		dir_rows.push_back(row(CMD_NEW, 4, 0, 0, 0, 1, 0, STAT_OK));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset shows up as a long req_stall
		foreach (dir_rows[i])
			drive_command(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
		for (int n = 0; n < RANDOM_ITEMS; n++)
			drive_command(pick_command(), 1'b0, none);
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// a trailing result would show up as unexpected here
		waited = 0;
		while (waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (error_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: single_level_page_table_mmu.f
rtl/core/slpt_pkg.sv
rtl/core/slpt_ram.sv
rtl/core/single_level_page_table_mmu.sv
test/tb_single_level_page_table_mmu.sv
